>>> rtl/tiba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiba_pkg: shared types and constants of the typed ID bitmap allocator
// Field widths, status codes, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package tiba_pkg;

    localparam int ID_LIMIT_W   = 9;
    localparam int REL_W        = 8;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 9;
    localparam int CHUNK_W      = 64;   // bitmap bits looked at per scan step
    localparam int DEF_MAX_IDS  = 256;
    localparam int ID_LIMIT_RST = 256;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_LIMIT    = 3'd1,
        ST_NO_SLOT  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOT_USED = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

endpackage

>>> rtl/typed_id_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_id_bitmap_allocator: first-free ID allocator with worker/control types
// Hands out the lowest free ID below the limit and takes IDs back.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate walks the used bitmap in
// 64-bit chunks, one chunk per cycle through a single find-first-free unit,
// and looks at 1 to 4 chunks with a limit of 256; an allocate refused by
// the limit skips the scan. A free goes through a check, a type lookup in
// the worker-map RAM and a count update; a refused ID ends after the check.
// The result sits in an output register, so the next request is taken while
// a result still waits downstream. id_limit may be written at any time the
// block is idle; the write port is always ready.
module typed_id_bitmap_allocator
    import tiba_pkg::*;
#(
    parameter int MAX_IDS = DEF_MAX_IDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request: tuser = cmd
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // is_worker[0], release_id[8:1]
    input  logic                  i_s_axis_tuser,   // cmd[0]
    // result
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // status[2:0], granted_id[10:3],
                                                    // total_in_use[19:11],
                                                    // workers_in_use[28:20],
                                                    // controls_in_use[37:29]
    // id_limit write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ID_LIMIT_W-1:0] i_cfg_data
);

    localparam int ID_W   = $clog2(MAX_IDS);
    localparam int NCHUNK = (MAX_IDS + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int CC_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int BIT_W  = $clog2(CHUNK_W);
    localparam int GID_W  = CC_W + BIT_W;
    localparam int LIM_W  = ($clog2(MAX_IDS + 1) > ID_LIMIT_W) ? $clog2(MAX_IDS + 1)
                                                                 : ID_LIMIT_W;
    localparam int RW     = ((GID_W > ID_LIMIT_W) ? GID_W : ID_LIMIT_W) + 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_FCHK = 5'b00100,
        S_FUPD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // control state
    t_state                r_state, n_state;
    logic [MAX_IDS-1:0]    r_used, n_used;
    logic [COUNT_W-1:0]    r_total, n_total;
    logic [COUNT_W-1:0]    r_work, n_work;
    logic [COUNT_W-1:0]    r_ctrl, n_ctrl;
    logic [ID_LIMIT_W-1:0] r_id_limit, n_id_limit;
    logic                  r_out_valid, n_out_valid;
    logic [CC_W-1:0]       r_chunk, n_chunk;

    // payload
    logic                  r_is_worker, n_is_worker;
    logic [REL_W-1:0]      r_rel, n_rel;
    t_status               r_res_status, n_res_status;
    logic [REL_W-1:0]      r_res_id, n_res_id;
    t_status               r_out_status, n_out_status;
    logic [REL_W-1:0]      r_out_id, n_out_id;
    logic [COUNT_W-1:0]    r_out_total, n_out_total;
    logic [COUNT_W-1:0]    r_out_work, n_out_work;
    logic [COUNT_W-1:0]    r_out_ctrl, n_out_ctrl;

    logic [ID_LIMIT_W-1:0] w_eff;
    logic [GID_W-1:0]      w_base;
    logic [RW-1:0]         w_rem;
    logic [PAD_W-1:0]      w_used_pad;
    logic [CHUNK_W-1:0]    w_chunk;
    logic [CHUNK_W-1:0]    w_elig;
    logic [CHUNK_W-1:0]    w_free;
    logic [CHUNK_W-1:0]    w_low;
    logic [BIT_W-1:0]      w_bit;
    logic                  w_hit;
    logic                  w_last;
    logic [GID_W-1:0]      w_gid;
    logic [ID_W-1:0]       w_gid_id;
    logic [ID_W-1:0]       w_rel_id;
    logic                  w_accept;
    logic                  w_ram_we;
    logic                  w_ram_rdata;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_eff    = (LIM_W'(r_id_limit) > LIM_W'(MAX_IDS)) ? ID_LIMIT_W'(MAX_IDS)
                                                             : r_id_limit;

    // find-first-free over one chunk, masked to IDs below the limit
    assign w_base     = {r_chunk, BIT_W'(0)};
    assign w_rem      = RW'(w_eff) - RW'(w_base);
    assign w_used_pad = PAD_W'(r_used);
    assign w_chunk    = w_used_pad[w_base +: CHUNK_W];

    always_comb begin
        for (int k = 0; k < CHUNK_W; k++) begin
            w_elig[k] = (RW'(k) < w_rem);
        end
    end

    assign w_free = ~w_chunk & w_elig;
    assign w_low  = w_free & (~w_free + CHUNK_W'(1));
    assign w_hit  = |w_free;

    always_comb begin
        w_bit = '0;
        for (int k = 0; k < CHUNK_W; k++) begin
            w_bit = w_bit | (w_low[k] ? BIT_W'(k) : BIT_W'(0));
        end
    end

    assign w_last   = (w_rem <= RW'(CHUNK_W)) || (r_chunk == CC_W'(NCHUNK - 1));
    assign w_gid    = {r_chunk, w_bit};
    assign w_gid_id = ID_W'(w_gid);
    assign w_rel_id = ID_W'(r_rel);
    assign w_ram_we = (r_state == S_SCAN) && w_hit;

    // type of each ID in use; its read data is only used for IDs marked used
    tiba_ram #(
        .WIDTH (1),
        .DEPTH (MAX_IDS)
    ) u_worker_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_gid_id),
        .i_wdata (r_is_worker),
        .i_raddr (w_rel_id),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_total      = r_total;
        n_work       = r_work;
        n_ctrl       = r_ctrl;
        n_chunk      = r_chunk;
        n_is_worker  = r_is_worker;
        n_rel        = r_rel;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_id_limit   = i_cfg_valid ? i_cfg_data : r_id_limit;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_total  = r_out_total;
        n_out_work   = r_out_work;
        n_out_ctrl   = r_out_ctrl;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_is_worker = i_s_axis_tdata[0];
                    n_rel       = i_s_axis_tdata[REL_W:1];
                    n_res_id    = '0;
                    n_chunk     = '0;
                    if (t_cmd'(i_s_axis_tuser) == CMD_FREE) begin
                        n_state = S_FCHK;
                    end else if (r_total >= w_eff) begin
                        n_res_status = ST_LIMIT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_used[w_gid_id] = 1'b1;
                    n_total          = r_total + COUNT_W'(1);
                    if (r_is_worker) begin
                        n_work = r_work + COUNT_W'(1);
                    end else begin
                        n_ctrl = r_ctrl + COUNT_W'(1);
                    end
                    n_res_status = ST_OK;
                    n_res_id     = REL_W'(w_gid);
                    n_state      = S_DONE;
                end else if (w_last) begin
                    n_res_status = ST_NO_SLOT;
                    n_state      = S_DONE;
                end else begin
                    n_chunk = r_chunk + CC_W'(1);
                end
            end
            S_FCHK: begin
                if (ID_LIMIT_W'(r_rel) >= w_eff) begin
                    n_res_status = ST_RANGE;
                    n_state      = S_DONE;
                end else if (!r_used[w_rel_id]) begin
                    n_res_status = ST_NOT_USED;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_FUPD;   // worker-map read in flight
                end
            end
            S_FUPD: begin
                n_used[w_rel_id] = 1'b0;
                n_total          = r_total - COUNT_W'(1);
                if (w_ram_rdata) begin
                    n_work = r_work - COUNT_W'(1);
                end else begin
                    n_ctrl = r_ctrl - COUNT_W'(1);
                end
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_total  = r_total;
                    n_out_work   = r_work;
                    n_out_ctrl   = r_ctrl;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_total     <= '0;
            r_work      <= '0;
            r_ctrl      <= '0;
            r_id_limit  <= ID_LIMIT_W'(ID_LIMIT_RST);
            r_out_valid <= 1'b0;
            r_chunk     <= '0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_total     <= n_total;
            r_work      <= n_work;
            r_ctrl      <= n_ctrl;
            r_id_limit  <= n_id_limit;
            r_out_valid <= n_out_valid;
            r_chunk     <= n_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_worker  <= n_is_worker;
        r_rel        <= n_rel;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_total  <= n_out_total;
        r_out_work   <= n_out_work;
        r_out_ctrl   <= n_out_ctrl;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_ctrl, r_out_work, r_out_total, r_out_id,
                              STATUS_W'(r_out_status)};

`ifndef SYNTH
    // the per-type counts always add up to the total
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == COUNT_W'(r_work + r_ctrl))
        else $error("type counts do not add up to total");

    // scan never walks past the last chunk
    a_scan_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_chunk <= CC_W'(NCHUNK - 1)))
        else $error("scan chunk beyond bitmap");

    // a found ID is always below the effective limit
    a_grant_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && w_hit) |-> (RW'(w_gid) < RW'(w_eff)))
        else $error("granted ID not below limit");
`endif

endmodule

>>> rtl/tiba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tiba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
